/* src/gtg_pkg.sv */
// Shared types and constants for the go-to-goal heading PID controller.
// No dependencies; imported by go_to_goal_heading_pid.
package gtg_pkg;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DELTA,
    S_SQ,
    S_SQRT,
    S_ARR,
    S_QUAT,
    S_CLOAD,
    S_CNORM,
    S_CITER,
    S_CEND,
    S_ERR,
    S_PID,
    S_FIN
  } state_e;

  localparam logic [2:0] REG_GOAL_X        = 3'd0;
  localparam logic [2:0] REG_GOAL_Y        = 3'd1;
  localparam logic [2:0] REG_BASE_SPEED    = 3'd2;
  localparam logic [2:0] REG_GAIN_P        = 3'd3;
  localparam logic [2:0] REG_GAIN_I        = 3'd4;
  localparam logic [2:0] REG_GAIN_D        = 3'd5;
  localparam logic [2:0] REG_ARRIVE_RADIUS = 3'd6;

  localparam int CW = 44;

  localparam logic signed [16:0] PI_Q13     = 17'sd25736;
  localparam logic signed [16:0] TWO_PI_Q13 = 17'sd51472;
  localparam logic signed [19:0] HALF_PI_Q16 = 20'sd102944;
  localparam logic [23:0] DIST_MAX = 24'hFFFFFF;

  function automatic logic [15:0] atan_f(input logic [3:0] idx);
    logic [15:0] v;
    case (idx)
      4'd0:    v = 16'd51472;
      4'd1:    v = 16'd30386;
      4'd2:    v = 16'd16055;
      4'd3:    v = 16'd8150;
      4'd4:    v = 16'd4091;
      4'd5:    v = 16'd2047;
      4'd6:    v = 16'd1024;
      4'd7:    v = 16'd512;
      4'd8:    v = 16'd256;
      4'd9:    v = 16'd128;
      4'd10:   v = 16'd64;
      4'd11:   v = 16'd32;
      4'd12:   v = 16'd16;
      4'd13:   v = 16'd8;
      4'd14:   v = 16'd4;
      4'd15:   v = 16'd2;
      default: v = 16'd0;
    endcase
    return v;
  endfunction

endpackage

/* src/go_to_goal_heading_pid.sv */
// Go-to-goal heading PID controller: one odometry transaction in, one command out.
// Unless the goal is already reached, a transaction runs the bit-serial square root (skipped
// when far off) and, unless it arrives, the CORDIC shift-normalize loop and the
// 16-step CORDIC run twice on one shared rotator and one shared 25x25 multiplier.
// Throughput: one transaction at a time; the next is taken when the sequencer is idle.
// Reset (rst_ni low, asynchronous) restores register defaults and clears PID state.
module go_to_goal_heading_pid
  import gtg_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  // pos_x[31:0], pos_y[63:32], quat_x[79:64], quat_y[95:80], quat_z[111:96], quat_w[127:112]
  input  logic [127:0]  s_axis_tdata,
  // restart
  input  logic          s_axis_tuser,
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  // linear_speed[23:0], angular_rate[55:24], err_p[71:56], err_i[95:72], err_d[112:96]
  output logic [119:0]  m_axis_tdata,
  // arrived
  output logic          m_axis_tuser,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [4:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready
);

  logic signed [31:0] goal_x_q, goal_y_q;
  logic [23:0] base_speed_q, arrive_radius_q;
  logic signed [15:0] gain_p_q, gain_i_q, gain_d_q;

  state_e state_q, state_d;
  logic [4:0] cnt_q;

  logic signed [31:0] px_q, py_q;
  logic signed [15:0] qx_q, qy_q, qz_q, qw_q;
  logic signed [32:0] dx_q, dy_q;
  logic [49:0] rem_q, bit_q;
  logic [49:0] root_q;
  logic [23:0] dist_q;
  logic signed [33:0] num_q, den_q;
  logic signed [49:0] prod_q;
  logic signed [24:0] mul_a, mul_b;
  logic signed [CW-1:0] cx_q, cy_q;
  logic signed [19:0] cz_q;
  logic pass_q;
  logic signed [15:0] yaw_q, brg_q;
  logic signed [15:0] e_q, prev_q;
  logic signed [23:0] sum_q, esum_q;
  logic signed [16:0] d_q;
  logic signed [CW-1:0] acc_q;
  logic done_q, zero_q;

  logic m_valid_q;
  logic [119:0] m_data_q;
  logic m_user_q;

  logic wr_en;
  logic accept;
  logic signed [32:0] dx_w, dy_w;
  logic far_w;
  logic [49:0] trial_w;
  logic [23:0] dist_w;
  logic signed [CW-1:0] ix_w, iy_w;
  logic signed [CW-1:0] ax_w, ay_w;
  logic big_w;
  logic signed [CW-1:0] sx_w, sy_w;
  logic signed [19:0] zr_w;
  logic signed [15:0] r_w;
  logic signed [16:0] diff_w, wrap_w;
  logic signed [24:0] sum_w;
  logic signed [23:0] sumsat_w;
  logic signed [CW-1:0] racc_w;
  logic signed [31:0] rate_w;
  logic [23:0] speed_w;
  logic fin_go;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;

  always_comb begin
    case (paddr[4:2])
      REG_GOAL_X:        prdata = goal_x_q;
      REG_GOAL_Y:        prdata = goal_y_q;
      REG_BASE_SPEED:    prdata = {8'd0, base_speed_q};
      REG_GAIN_P:        prdata = {16'd0, gain_p_q};
      REG_GAIN_I:        prdata = {16'd0, gain_i_q};
      REG_GAIN_D:        prdata = {16'd0, gain_d_q};
      REG_ARRIVE_RADIUS: prdata = {8'd0, arrive_radius_q};
      default:           prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      goal_x_q        <= '0;
      goal_y_q        <= '0;
      base_speed_q    <= 24'd65536;
      gain_p_q        <= 16'sd1024;
      gain_i_q        <= 16'sd0;
      gain_d_q        <= 16'sd512;
      arrive_radius_q <= 24'd6554;
    end else if (wr_en) begin
      case (paddr[4:2])
        REG_GOAL_X:        goal_x_q <= pwdata;
        REG_GOAL_Y:        goal_y_q <= pwdata;
        REG_BASE_SPEED:    base_speed_q <= pwdata[23:0];
        REG_GAIN_P:        gain_p_q <= pwdata[15:0];
        REG_GAIN_I:        gain_i_q <= pwdata[15:0];
        REG_GAIN_D:        gain_d_q <= pwdata[15:0];
        REG_ARRIVE_RADIUS: arrive_radius_q <= pwdata[23:0];
        default:           ;
      endcase
    end
  end

  assign s_axis_tready = (state_q == S_IDLE);
  assign accept        = s_axis_tvalid & s_axis_tready;
  assign fin_go        = ~m_valid_q | m_axis_tready;

  // Datapath combinational terms.
  always_comb begin
    dx_w  = {goal_x_q[31], goal_x_q} - {px_q[31], px_q};
    dy_w  = {goal_y_q[31], goal_y_q} - {py_q[31], py_q};
    far_w = (dx_w >= 33'sd16777216) || (dx_w <= -33'sd16777216) ||
            (dy_w >= 33'sd16777216) || (dy_w <= -33'sd16777216);
    trial_w = root_q + bit_q;
    dist_w  = (root_q > {26'd0, DIST_MAX}) ? DIST_MAX : root_q[23:0];
    if (pass_q) begin
      iy_w = CW'(dy_q);
      ix_w = CW'(dx_q);
    end else begin
      iy_w = CW'(num_q) <<< 1;
      ix_w = (CW'(1) <<< 28) - (CW'(den_q) <<< 1);
    end
    ax_w  = cx_q[CW-1] ? -cx_q : cx_q;
    ay_w  = cy_q[CW-1] ? -cy_q : cy_q;
    big_w = (ax_w >= (CW'(1) <<< 38)) || (ay_w >= (CW'(1) <<< 38));
    sx_w  = cy_q >>> cnt_q[3:0];
    sy_w  = cx_q >>> cnt_q[3:0];
    zr_w  = (cz_q + 20'sd4) >>> 3;
    if (zr_w > 20'(PI_Q13)) begin
      r_w = 16'(PI_Q13);
    end else if (zr_w < -20'(PI_Q13)) begin
      r_w = -16'(PI_Q13);
    end else begin
      r_w = zr_w[15:0];
    end
    diff_w = 17'(brg_q) - 17'(yaw_q);
    if (diff_w < -PI_Q13) begin
      wrap_w = diff_w + TWO_PI_Q13;
    end else if (diff_w > PI_Q13) begin
      wrap_w = diff_w - TWO_PI_Q13;
    end else begin
      wrap_w = diff_w;
    end
    sum_w = 25'(esum_q) + 25'(wrap_w);
    if (sum_w > 25'sd8388607) begin
      sumsat_w = 24'sd8388607;
    end else if (sum_w < -25'sd8388608) begin
      sumsat_w = -24'sd8388608;
    end else begin
      sumsat_w = sum_w[23:0];
    end
    racc_w = (acc_q + CW'(16)) >>> 5;
    if (racc_w > CW'(32'sh7FFFFFFF)) begin
      rate_w = 32'sh7FFFFFFF;
    end else if (racc_w < CW'(-33'sh80000000)) begin
      rate_w = 32'sh80000000;
    end else begin
      rate_w = racc_w[31:0];
    end
    speed_w = (dist_q > base_speed_q) ? base_speed_q : dist_q;
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      S_SQ: begin
        mul_a = cnt_q[0] ? dy_q[24:0] : dx_q[24:0];
        mul_b = cnt_q[0] ? dy_q[24:0] : dx_q[24:0];
      end
      S_QUAT: begin
        case (cnt_q[1:0])
          2'd0:    begin mul_a = 25'(qw_q); mul_b = 25'(qz_q); end
          2'd1:    begin mul_a = 25'(qx_q); mul_b = 25'(qy_q); end
          2'd2:    begin mul_a = 25'(qy_q); mul_b = 25'(qy_q); end
          default: begin mul_a = 25'(qz_q); mul_b = 25'(qz_q); end
        endcase
      end
      S_PID: begin
        case (cnt_q[1:0])
          2'd0:    begin mul_a = 25'(gain_p_q); mul_b = 25'(e_q); end
          2'd1:    begin mul_a = 25'(gain_i_q); mul_b = 25'(sum_q); end
          default: begin mul_a = 25'(gain_d_q); mul_b = 25'(d_q); end
        endcase
      end
      default: ;
    endcase
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:  if (s_axis_tvalid) state_d = (done_q & ~s_axis_tuser) ? S_FIN : S_DELTA;
      S_DELTA: state_d = far_w ? S_ARR : S_SQ;
      S_SQ:    if (cnt_q == 5'd2) state_d = S_SQRT;
      S_SQRT:  if (cnt_q == 5'd24) state_d = S_ARR;
      S_ARR:   state_d = (dist_w < arrive_radius_q) ? S_FIN : S_QUAT;
      S_QUAT:  if (cnt_q == 5'd4) state_d = S_CLOAD;
      S_CLOAD: state_d = (ix_w == '0 && iy_w == '0) ? S_CEND : S_CNORM;
      S_CNORM: if (big_w) state_d = S_CITER;
      S_CITER: if (cnt_q == 5'd15) state_d = S_CEND;
      S_CEND:  state_d = pass_q ? S_ERR : S_CLOAD;
      S_ERR:   state_d = S_PID;
      S_PID:   if (cnt_q == 5'd3) state_d = S_FIN;
      S_FIN:   if (fin_go) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      cnt_q     <= '0;
      done_q    <= 1'b0;
      prev_q    <= '0;
      esum_q    <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= (state_d != state_q) ? 5'd0 : cnt_q + 5'd1;
      if (accept && s_axis_tuser) begin
        done_q <= 1'b0;
        prev_q <= '0;
        esum_q <= '0;
      end
      if (state_q == S_ARR && dist_w < arrive_radius_q) begin
        done_q <= 1'b1;
      end
      if (state_q == S_FIN && fin_go) begin
        m_valid_q <= 1'b1;
        if (!zero_q) begin
          prev_q <= e_q;
          esum_q <= sum_q;
        end
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
    case (state_q)
      S_IDLE: begin
        px_q   <= s_axis_tdata[31:0];
        py_q   <= s_axis_tdata[63:32];
        qx_q   <= s_axis_tdata[79:64];
        qy_q   <= s_axis_tdata[95:80];
        qz_q   <= s_axis_tdata[111:96];
        qw_q   <= s_axis_tdata[127:112];
        pass_q <= 1'b0;
        zero_q <= 1'b1;
      end
      S_DELTA: begin
        dx_q   <= dx_w;
        dy_q   <= dy_w;
        root_q <= {26'd0, DIST_MAX};
      end
      S_SQ: begin
        if (cnt_q == 5'd1) rem_q <= prod_q[49:0];
        if (cnt_q == 5'd2) rem_q <= rem_q + prod_q[49:0];
        bit_q  <= 50'd1 << 48;
        root_q <= '0;
      end
      S_SQRT: begin
        if (rem_q >= trial_w) begin
          rem_q  <= rem_q - trial_w;
          root_q <= (root_q >> 1) + bit_q;
        end else begin
          root_q <= root_q >> 1;
        end
        bit_q <= bit_q >> 2;
      end
      S_ARR: begin
        dist_q <= dist_w;
        zero_q <= (dist_w < arrive_radius_q);
      end
      S_QUAT: begin
        case (cnt_q[2:0])
          3'd1:    num_q <= 34'(prod_q);
          3'd2:    num_q <= num_q + 34'(prod_q);
          3'd3:    den_q <= 34'(prod_q);
          3'd4:    den_q <= den_q + 34'(prod_q);
          default: ;
        endcase
      end
      S_CLOAD: begin
        if (ix_w < 0) begin
          if (iy_w >= 0) begin
            cx_q <= iy_w;
            cy_q <= -ix_w;
            cz_q <= HALF_PI_Q16;
          end else begin
            cx_q <= -iy_w;
            cy_q <= ix_w;
            cz_q <= -HALF_PI_Q16;
          end
        end else begin
          cx_q <= ix_w;
          cy_q <= iy_w;
          cz_q <= '0;
        end
      end
      S_CNORM: begin
        if (!big_w) begin
          cx_q <= cx_q <<< 1;
          cy_q <= cy_q <<< 1;
        end
      end
      S_CITER: begin
        if (!cy_q[CW-1]) begin
          cx_q <= cx_q + sx_w;
          cy_q <= cy_q - sy_w;
          cz_q <= cz_q + 20'(atan_f(cnt_q[3:0]));
        end else begin
          cx_q <= cx_q - sx_w;
          cy_q <= cy_q + sy_w;
          cz_q <= cz_q - 20'(atan_f(cnt_q[3:0]));
        end
      end
      S_CEND: begin
        if (pass_q) brg_q <= r_w;
        else yaw_q <= r_w;
        pass_q <= 1'b1;
      end
      S_ERR: begin
        e_q   <= wrap_w[15:0];
        sum_q <= sumsat_w;
        d_q   <= wrap_w - 17'(prev_q);
      end
      S_PID: begin
        if (cnt_q == 5'd1) acc_q <= CW'(prod_q);
        if (cnt_q == 5'd2 || cnt_q == 5'd3) acc_q <= acc_q + CW'(prod_q);
      end
      S_FIN: begin
        if (fin_go) begin
          if (zero_q) begin
            m_data_q <= '0;
            m_user_q <= 1'b1;
          end else begin
            m_data_q <= {7'd0, d_q, sum_q, e_q, rate_w, speed_w};
            m_user_q <= 1'b0;
          end
        end
      end
      default: ;
    endcase
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;

endmodule
